>>> rtl/stereo_dry_wet_crossfade_defines.svh
// Assertion macros for the stereo dry/wet crossfade checker.
// No dependencies; taken in by the checker file only.
`ifndef STEREO_DRY_WET_CROSSFADE_DEFINES_SVH
`define STEREO_DRY_WET_CROSSFADE_DEFINES_SVH

// Same-cycle implication.
`define SDWC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDWC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sdwc_pkg.sv
// Shared types, constants and coefficient table for the crossfade block.
// No dependencies.
package sdwc_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int GAIN_W      = 17;
   localparam int LEN_W       = 13;
   localparam int DIVR_W      = 12;
   localparam int T_W         = 31;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 64;
   localparam int MACC_W      = 42;
   localparam int GNUM_W      = 47;
   localparam int CNT_W       = 5;
   localparam int TDIV_STEPS  = 30;
   localparam int GDIV_STEPS  = 17;
   localparam int MIX_STEPS   = 4;
   localparam int COEF_LAST   = 5;

   localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd480;
   localparam logic [LEN_W-1:0]  MAX_FADE   = 13'd4096;
   localparam logic [T_W-1:0]    Q30_ONE    = 31'h4000_0000;
   localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h1_0000;

   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_ABORT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TDIV_INIT, ST_TDIV, ST_SN_SQ, ST_SN_X2, ST_SN_MUL, ST_SN_ADD,
      ST_SN_MULX, ST_SN_SAVE, ST_GD_INIT, ST_GD_STEP, ST_ONE, ST_MX_MUL, ST_MX_ADD,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_DIV_INIT, DP_DIV_STEP, DP_MUL_XX, DP_SET_X2, DP_MUL_ACC_X2,
      DP_ACC_ADD, DP_MUL_ACC_X, DP_SIN_SAVE, DP_GDIV_INIT, DP_GDIV_STEP, DP_GAIN_ONE,
      DP_MUL_MIX, DP_MIX_ADD, DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic              sel;
      logic [2:0]        coef_idx;
      logic [1:0]        mix_idx;
      logic              pass;
      logic [DIVR_W-1:0] pos;
      logic [DIVR_W-1:0] divisor;
      logic              fading;
      logic [LEN_W-1:0]  frames_left;
   } dp_cmd_type;

   // Odd sine polynomial coefficients, signed Q1.30, lowest order first.
   function automatic logic signed [MUL_W-1:0] sin_coef(input logic [2:0] k);
      logic signed [MUL_W-1:0] c;
      case (k)
         3'd0:    c = 32'sd1686629713;
         3'd1:    c = -32'sd693598668;
         3'd2:    c = 32'sd85569306;
         3'd3:    c = -32'sd5026995;
         3'd4:    c = 32'sd172272;
         3'd5:    c = -32'sd3864;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] n;
      if (len == '0)
         n = 13'd1;
      else if (len > MAX_FADE)
         n = MAX_FADE;
      else
         n = len;
      return n;
   endfunction

endpackage

>>> rtl/sdwc_if.sv
// Channel interfaces: request, response and register write.
// Depends on sdwc_pkg.
interface sdwc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             operation;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   wet_left;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   wet_right;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   dry_left;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   dry_right;
   logic                                   block_end;
   modport source (output valid, operation, wet_left, wet_right, dry_left, dry_right,
                   block_end, input ready);
   modport sink (input valid, operation, wet_left, wet_right, dry_left, dry_right,
                 block_end, output ready);
endinterface

interface sdwc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   mixed_left;
   logic signed [sdwc_pkg::SAMPLE_W-1:0]   mixed_right;
   logic                                   fading;
   logic [sdwc_pkg::LEN_W-1:0]             frames_left;
   logic                                   block_end_out;
   modport source (output valid, mixed_left, mixed_right, fading, frames_left,
                   block_end_out, input ready);
   modport sink (input valid, mixed_left, mixed_right, fading, frames_left,
                 block_end_out, output ready);
endinterface

interface sdwc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sdwc_pkg::LEN_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/sdwc_datapath.sv
// Crossfade datapath: position divider, shared multiplier, sine polynomial,
// gain divider, mixer with saturation and result registers. Depends on sdwc_pkg.
module sdwc_datapath (
   input  logic                                 clock,
   input  sdwc_pkg::dp_cmd_type                 cmd,
   input  logic signed [sdwc_pkg::SAMPLE_W-1:0] wet_left,
   input  logic signed [sdwc_pkg::SAMPLE_W-1:0] wet_right,
   input  logic signed [sdwc_pkg::SAMPLE_W-1:0] dry_left,
   input  logic signed [sdwc_pkg::SAMPLE_W-1:0] dry_right,
   input  logic                                 block_end,
   output logic signed [sdwc_pkg::SAMPLE_W-1:0] mixed_left,
   output logic signed [sdwc_pkg::SAMPLE_W-1:0] mixed_right,
   output logic                                 fading,
   output logic [sdwc_pkg::LEN_W-1:0]           frames_left,
   output logic                                 block_end_out
);

   localparam int SW = sdwc_pkg::SAMPLE_W;
   localparam int MW = sdwc_pkg::MUL_W;
   localparam int PW = sdwc_pkg::PROD_W;
   localparam int AW = sdwc_pkg::MACC_W;
   localparam int TW = sdwc_pkg::T_W;
   localparam int DW = sdwc_pkg::DIVR_W;
   localparam int GW = sdwc_pkg::GAIN_W;
   localparam int NW = sdwc_pkg::GNUM_W;
   localparam int RW = AW - 16;

   logic signed [SW-1:0] wet_l_ff, wet_r_ff, dry_l_ff, dry_r_ff;
   logic                 blk_ff;
   logic [DW-1:0]        rem_ff;
   logic [TW-1:0]        t_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [MW-1:0] x2_ff, acc_ff;
   logic [TW-1:0]        s_ff, c_ff;
   logic [MW-1:0]        sum_ff, grem_ff;
   logic [GW-1:0]        glow_ff, gq_ff;
   logic signed [AW-1:0] macc_ff;
   logic signed [SW-1:0] mix_l_ff, mix_r_ff;
   logic signed [SW-1:0] out_l_ff, out_r_ff;
   logic                 fading_ff, blk_out_ff;
   logic [sdwc_pkg::LEN_W-1:0] frames_ff;

   logic [TW-1:0]        x_sel;
   logic [GW-1:0]        dry_g;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_in, prod_adj, prod_sh;
   logic signed [MW-1:0] trq;
   logic [TW-1:0]        clamped;
   logic [DW:0]          r2;
   logic                 r_ge;
   logic [MW-1:0]        sum_in;
   logic [NW-1:0]        gnum;
   logic [MW:0]          gr2;
   logic                 g_ge;
   logic signed [AW-1:0] mbase, msum;
   logic signed [RW-1:0] mres;
   logic signed [SW-1:0] msat;

   always_comb begin
      x_sel = cmd.sel ? TW'(sdwc_pkg::Q30_ONE - t_ff) : t_ff;
      dry_g = GW'(sdwc_pkg::GAIN_ONE - gq_ff);
      case (cmd.op)
         sdwc_pkg::DP_MUL_XX: begin
            mul_a = {1'b0, x_sel};
            mul_b = {1'b0, x_sel};
         end
         sdwc_pkg::DP_MUL_ACC_X2: begin
            mul_a = acc_ff;
            mul_b = x2_ff;
         end
         sdwc_pkg::DP_MUL_ACC_X: begin
            mul_a = acc_ff;
            mul_b = {1'b0, x_sel};
         end
         sdwc_pkg::DP_MUL_MIX: begin
            case (cmd.mix_idx)
               2'd0: begin
                  mul_a = {{(MW-SW){dry_l_ff[SW-1]}}, dry_l_ff};
                  mul_b = {{(MW-GW){1'b0}}, dry_g};
               end
               2'd1: begin
                  mul_a = {{(MW-SW){wet_l_ff[SW-1]}}, wet_l_ff};
                  mul_b = {{(MW-GW){1'b0}}, gq_ff};
               end
               2'd2: begin
                  mul_a = {{(MW-SW){dry_r_ff[SW-1]}}, dry_r_ff};
                  mul_b = {{(MW-GW){1'b0}}, dry_g};
               end
               default: begin
                  mul_a = {{(MW-SW){wet_r_ff[SW-1]}}, wet_r_ff};
                  mul_b = {{(MW-GW){1'b0}}, gq_ff};
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;

      // Q30 product, truncated toward zero
      prod_adj = prod_ff[PW-1] ? prod_ff + 64'sd1073741823 : prod_ff;
      prod_sh  = prod_adj >>> 30;
      trq      = prod_sh[MW-1:0];
      if (trq < 0)
         clamped = '0;
      else if (trq > 32'sd1073741824)
         clamped = sdwc_pkg::Q30_ONE;
      else
         clamped = trq[TW-1:0];

      r2   = {rem_ff, 1'b0};
      r_ge = r2 >= {1'b0, cmd.divisor};

      sum_in = {1'b0, s_ff} + {1'b0, c_ff};
      gnum   = {s_ff, 16'b0} + NW'(sum_in >> 1);
      gr2    = {grem_ff, glow_ff[GW-1]};
      g_ge   = gr2 >= {1'b0, sum_ff};

      mbase = cmd.mix_idx[0] ? macc_ff : 42'sd32768;
      msum  = mbase + prod_ff[AW-1:0];
      mres  = msum[AW-1:16];
      if (mres > 26'sd8388607)
         msat = 24'sh7FFFFF;
      else if (mres < -26'sd8388608)
         msat = 24'sh800000;
      else
         msat = mres[SW-1:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         sdwc_pkg::DP_LOAD: begin
            wet_l_ff <= wet_left;
            wet_r_ff <= wet_right;
            dry_l_ff <= dry_left;
            dry_r_ff <= dry_right;
            blk_ff   <= block_end;
         end
         sdwc_pkg::DP_DIV_INIT: begin
            if (cmd.pos >= cmd.divisor) begin
               rem_ff <= DW'(cmd.pos - cmd.divisor);
               t_ff   <= TW'(1);
            end else begin
               rem_ff <= cmd.pos;
               t_ff   <= '0;
            end
         end
         sdwc_pkg::DP_DIV_STEP: begin
            rem_ff <= r_ge ? DW'(r2 - {1'b0, cmd.divisor}) : r2[DW-1:0];
            t_ff   <= {t_ff[TW-2:0], r_ge};
         end
         sdwc_pkg::DP_MUL_XX, sdwc_pkg::DP_MUL_ACC_X2, sdwc_pkg::DP_MUL_ACC_X,
         sdwc_pkg::DP_MUL_MIX: begin
            prod_ff <= prod_in;
         end
         sdwc_pkg::DP_SET_X2: begin
            x2_ff  <= trq;
            acc_ff <= sdwc_pkg::sin_coef(3'(sdwc_pkg::COEF_LAST));
         end
         sdwc_pkg::DP_ACC_ADD: begin
            acc_ff <= sdwc_pkg::sin_coef(cmd.coef_idx) + trq;
         end
         sdwc_pkg::DP_SIN_SAVE: begin
            if (cmd.sel)
               c_ff <= clamped;
            else
               s_ff <= clamped;
         end
         sdwc_pkg::DP_GDIV_INIT: begin
            sum_ff  <= sum_in;
            grem_ff <= MW'(gnum[NW-1:GW]);
            glow_ff <= gnum[GW-1:0];
            gq_ff   <= '0;
         end
         sdwc_pkg::DP_GDIV_STEP: begin
            grem_ff <= g_ge ? MW'(gr2 - {1'b0, sum_ff}) : gr2[MW-1:0];
            glow_ff <= {glow_ff[GW-2:0], 1'b0};
            gq_ff   <= {gq_ff[GW-2:0], g_ge};
         end
         sdwc_pkg::DP_GAIN_ONE: begin
            gq_ff <= sdwc_pkg::GAIN_ONE;
         end
         sdwc_pkg::DP_MIX_ADD: begin
            macc_ff <= msum;
            if (cmd.mix_idx == 2'd1)
               mix_l_ff <= msat;
            if (cmd.mix_idx == 2'd3)
               mix_r_ff <= msat;
         end
         sdwc_pkg::DP_EMIT: begin
            out_l_ff   <= cmd.pass ? wet_l_ff : mix_l_ff;
            out_r_ff   <= cmd.pass ? wet_r_ff : mix_r_ff;
            fading_ff  <= cmd.fading;
            frames_ff  <= cmd.frames_left;
            blk_out_ff <= blk_ff;
         end
         default: begin
         end
      endcase
   end

   assign mixed_left    = out_l_ff;
   assign mixed_right   = out_r_ff;
   assign fading        = fading_ff;
   assign frames_left   = frames_ff;
   assign block_end_out = blk_out_ff;

endmodule

>>> rtl/sdwc_controller.sv
// Crossfade controller: fade state, length register, sequencing of the
// datapath and the response valid flag. Depends on sdwc_pkg.
module sdwc_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sdwc_pkg::LEN_W-1:0]    csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sdwc_pkg::dp_cmd_type          cmd
);

   localparam int LW = sdwc_pkg::LEN_W;
   localparam int CW = sdwc_pkg::CNT_W;

   sdwc_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]    k_ff, k_in;
   logic          sel_ff, sel_in;
   logic          pass_ff, pass_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          active_ff, active_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [LW-1:0] n_eff, next_pos;
   logic          fade_more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdwc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         len_ff       <= sdwc_pkg::LEN_RESET;
         pos_ff       <= sdwc_pkg::LEN_RESET;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         pass_ff      <= pass_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      n_eff     = sdwc_pkg::eff_len(len_ff);
      next_pos  = LW'(pos_ff + 1'b1);
      fade_more = next_pos < n_eff;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      pass_in      = pass_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      csr_ready    = 1'b1;

      cmd.op          = sdwc_pkg::DP_NOP;
      cmd.sel         = sel_ff;
      cmd.coef_idx    = k_ff;
      cmd.mix_idx     = cnt_ff[1:0];
      cmd.pass        = pass_ff;
      cmd.pos         = pos_ff[sdwc_pkg::DIVR_W-1:0];
      cmd.divisor     = sdwc_pkg::DIVR_W'(n_eff - 1'b1);
      cmd.fading      = !pass_ff && fade_more;
      cmd.frames_left = (!pass_ff && fade_more) ? LW'(n_eff - next_pos) : '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         sdwc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = sdwc_pkg::DP_LOAD;
               case (req_operation)
                  sdwc_pkg::OP_START: begin
                     pos_in    = '0;
                     active_in = 1'b1;
                  end
                  sdwc_pkg::OP_ABORT: begin
                     pos_in    = n_eff;
                     active_in = 1'b0;
                  end
                  sdwc_pkg::OP_FRAME: begin
                     if (active_ff && pos_ff < n_eff) begin
                        pass_in  = 1'b0;
                        state_in = (n_eff == LW'(1)) ? sdwc_pkg::ST_ONE
                                                     : sdwc_pkg::ST_TDIV_INIT;
                     end else begin
                        active_in = 1'b0;
                        pass_in   = 1'b1;
                        state_in  = sdwc_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sdwc_pkg::ST_TDIV_INIT: begin
            cmd.op   = sdwc_pkg::DP_DIV_INIT;
            cnt_in   = '0;
            state_in = sdwc_pkg::ST_TDIV;
         end
         sdwc_pkg::ST_TDIV: begin
            cmd.op = sdwc_pkg::DP_DIV_STEP;
            if (cnt_ff == CW'(sdwc_pkg::TDIV_STEPS - 1)) begin
               sel_in   = 1'b0;
               state_in = sdwc_pkg::ST_SN_SQ;
            end else begin
               cnt_in = CW'(cnt_ff + 1'b1);
            end
         end
         sdwc_pkg::ST_SN_SQ: begin
            cmd.op   = sdwc_pkg::DP_MUL_XX;
            state_in = sdwc_pkg::ST_SN_X2;
         end
         sdwc_pkg::ST_SN_X2: begin
            cmd.op   = sdwc_pkg::DP_SET_X2;
            k_in     = 3'(sdwc_pkg::COEF_LAST - 1);
            state_in = sdwc_pkg::ST_SN_MUL;
         end
         sdwc_pkg::ST_SN_MUL: begin
            cmd.op   = sdwc_pkg::DP_MUL_ACC_X2;
            state_in = sdwc_pkg::ST_SN_ADD;
         end
         sdwc_pkg::ST_SN_ADD: begin
            cmd.op = sdwc_pkg::DP_ACC_ADD;
            if (k_ff == '0) begin
               state_in = sdwc_pkg::ST_SN_MULX;
            end else begin
               k_in     = 3'(k_ff - 1'b1);
               state_in = sdwc_pkg::ST_SN_MUL;
            end
         end
         sdwc_pkg::ST_SN_MULX: begin
            cmd.op   = sdwc_pkg::DP_MUL_ACC_X;
            state_in = sdwc_pkg::ST_SN_SAVE;
         end
         sdwc_pkg::ST_SN_SAVE: begin
            cmd.op = sdwc_pkg::DP_SIN_SAVE;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = sdwc_pkg::ST_SN_SQ;
            end else begin
               state_in = sdwc_pkg::ST_GD_INIT;
            end
         end
         sdwc_pkg::ST_GD_INIT: begin
            cmd.op   = sdwc_pkg::DP_GDIV_INIT;
            cnt_in   = '0;
            state_in = sdwc_pkg::ST_GD_STEP;
         end
         sdwc_pkg::ST_GD_STEP: begin
            cmd.op = sdwc_pkg::DP_GDIV_STEP;
            if (cnt_ff == CW'(sdwc_pkg::GDIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = sdwc_pkg::ST_MX_MUL;
            end else begin
               cnt_in = CW'(cnt_ff + 1'b1);
            end
         end
         sdwc_pkg::ST_ONE: begin
            cmd.op   = sdwc_pkg::DP_GAIN_ONE;
            cnt_in   = '0;
            state_in = sdwc_pkg::ST_MX_MUL;
         end
         sdwc_pkg::ST_MX_MUL: begin
            cmd.op   = sdwc_pkg::DP_MUL_MIX;
            state_in = sdwc_pkg::ST_MX_ADD;
         end
         sdwc_pkg::ST_MX_ADD: begin
            cmd.op = sdwc_pkg::DP_MIX_ADD;
            if (cnt_ff == CW'(sdwc_pkg::MIX_STEPS - 1)) begin
               state_in = sdwc_pkg::ST_EMIT;
            end else begin
               cnt_in   = CW'(cnt_ff + 1'b1);
               state_in = sdwc_pkg::ST_MX_MUL;
            end
         end
         sdwc_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = sdwc_pkg::DP_EMIT;
               rsp_valid_in = 1'b1;
               if (!pass_ff) begin
                  pos_in    = next_pos;
                  active_in = fade_more;
               end
               state_in = sdwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdwc_pkg::ST_IDLE;
         end
      endcase

      // a register write aborts the fade
      if (csr_valid) begin
         len_in    = csr_data;
         pos_in    = sdwc_pkg::eff_len(csr_data);
         active_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/stereo_dry_wet_crossfade.sv
// Channel     Dir  Handshake      Payload
// req_ch      in   valid/ready    operation, wet/dry left/right, block_end
// rsp_ch      out  valid/ready    mixed_left/right, fading, frames_left, block_end_out
// csr_ch      in   valid/ready    fade_length (13 bits)
//
// Start and abort transactions are taken in the idle state and leave the block
// ready. A frame outside a fade goes to the emit state, which loads the result
// registers once the output register is free. A frame inside a fade runs a 30-step
// position divider, two sine polynomials on the shared multiplier, a 17-step gain
// divider and four multiply-accumulates; for length one, the multiply-accumulates alone.
// A new request is taken while a finished result waits; a stalled response holds.
// Reset is synchronous: length 480, no fade running.
module stereo_dry_wet_crossfade (
   input  logic        clock,
   input  logic        reset,
   sdwc_req_if.sink    req_ch,
   sdwc_rsp_if.source  rsp_ch,
   sdwc_csr_if.sink    csr_ch
);

   sdwc_pkg::dp_cmd_type cmd;

   sdwc_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .csr_data      (csr_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd           (cmd)
   );

   sdwc_datapath u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .wet_left      (req_ch.wet_left),
      .wet_right     (req_ch.wet_right),
      .dry_left      (req_ch.dry_left),
      .dry_right     (req_ch.dry_right),
      .block_end     (req_ch.block_end),
      .mixed_left    (rsp_ch.mixed_left),
      .mixed_right   (rsp_ch.mixed_right),
      .fading        (rsp_ch.fading),
      .frames_left   (rsp_ch.frames_left),
      .block_end_out (rsp_ch.block_end_out)
   );

endmodule

>>> rtl/sdwc_checker.sv
// Port-level checker for the crossfade block, bound to the top level.
// Depends on sdwc_pkg and stereo_dry_wet_crossfade_defines.svh.
`include "stereo_dry_wet_crossfade_defines.svh"

module sdwc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [1:0]                           req_operation,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [sdwc_pkg::SAMPLE_W-1:0] rsp_mixed_left,
   input logic signed [sdwc_pkg::SAMPLE_W-1:0] rsp_mixed_right,
   input logic [sdwc_pkg::LEN_W-1:0]           rsp_frames_left
);

   `SDWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `SDWC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_mixed_left) && $stable(rsp_mixed_right) && $stable(rsp_frames_left), "response changed while stalled")
   `SDWC_ASSERT_NEXT(a_frame_busy, clock, reset, req_valid && req_ready && req_operation == sdwc_pkg::OP_FRAME, !req_ready, "frame transaction did not occupy the block")
   `SDWC_ASSERT_NEXT(a_ctrl_quick, clock, reset, req_valid && req_ready && req_operation != sdwc_pkg::OP_FRAME, req_ready, "control transaction held the block")

endmodule

bind stereo_dry_wet_crossfade sdwc_checker u_sdwc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_operation   (req_ch.operation),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_mixed_left  (rsp_ch.mixed_left),
   .rsp_mixed_right (rsp_ch.mixed_right),
   .rsp_frames_left (rsp_ch.frames_left)
);

>>> test/stereo_dry_wet_crossfade_checker.sv
// Checker for the stereo dry/wet crossfade: watches the request, response and
// register channels, predicts each frame's mix and compares it in order.
// Depends on sdwc_pkg and the channel interfaces in sdwc_if.sv.
`timescale 1ns / 1ps

module stereo_dry_wet_crossfade_checker (
   input  logic    clock,
   input  logic    reset,
   sdwc_req_if     req_ch,
   sdwc_rsp_if     rsp_ch,
   sdwc_csr_if     csr_ch,
   output int      fail_count,
   output int      pending_count
);

   localparam longint Q30 = 64'sd1 << 30;
   localparam longint UNITY_GAIN = 64'sd65536;
   localparam longint SINE_TERM [6] = '{64'sd1686629713, -64'sd693598668, 64'sd85569306,
                                         -64'sd5026995, 64'sd172272, -64'sd3864};

   typedef struct packed {
      logic signed [sdwc_pkg::SAMPLE_W-1:0] left;
      logic signed [sdwc_pkg::SAMPLE_W-1:0] right;
      logic                                 fading;
      logic [sdwc_pkg::LEN_W-1:0]           frames_left;
      logic                                 block_end;
   } mixed_frame_type;

   mixed_frame_type            mix_queue[$];
   logic [sdwc_pkg::LEN_W-1:0] length_reg;
   int unsigned                position;
   bit                         running;
   int                         mismatches;

   assign fail_count    = mismatches;
   assign pending_count = mix_queue.size();

   function automatic int unsigned frames_in_fade(input logic [sdwc_pkg::LEN_W-1:0] len);
      if (len == 0)
         return 1;
      if (len > 4096)
         return 4096;
      return len;
   endfunction

   function automatic longint sine_quadrant(input longint x);
      longint x2;
      longint acc;
      x2  = (x * x) / Q30;
      acc = SINE_TERM[5];
      for (int k = 4; k >= 0; k--)
         acc = SINE_TERM[k] + (acc * x2) / Q30;
      acc = (acc * x) / Q30;
      if (acc < 0)
         acc = 0;
      if (acc > Q30)
         acc = Q30;
      return acc;
   endfunction

   function automatic longint wet_share(input int unsigned pos, input int unsigned n);
      longint t;
      longint s;
      longint c;
      if (n <= 1)
         return UNITY_GAIN;
      t = (longint'(pos) << 30) / longint'(n - 1);
      if (t > Q30)
         t = Q30;
      s = sine_quadrant(t);
      c = sine_quadrant(Q30 - t);
      if (s + c == 0)
         return UNITY_GAIN;
      return (s * UNITY_GAIN + (s + c) / 2) / (s + c);
   endfunction

   function automatic logic signed [sdwc_pkg::SAMPLE_W-1:0] blend(input longint dry,
                                                                  input longint wet,
                                                                  input longint wg);
      longint v;
      v = (dry * (UNITY_GAIN - wg) + wet * wg + 32768) >>> 16;
      if (v > 64'sd8388607)
         v = 64'sd8388607;
      if (v < -64'sd8388608)
         v = -64'sd8388608;
      return v[sdwc_pkg::SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      mixed_frame_type want;
      mixed_frame_type got;
      int unsigned     n;
      longint          wg;
      if (reset) begin
         length_reg = sdwc_pkg::LEN_RESET;
         position   = frames_in_fade(sdwc_pkg::LEN_RESET);
         running    = 0;
         mix_queue.delete();
         mismatches = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            length_reg = csr_ch.data;
            position   = frames_in_fade(length_reg);
            running    = 0;
         end
         if (req_ch.valid && req_ch.ready) begin
            n = frames_in_fade(length_reg);
            case (req_ch.operation)
               sdwc_pkg::OP_START: begin
                  position = 0;
                  running  = 1;
               end
               sdwc_pkg::OP_ABORT: begin
                  position = n;
                  running  = 0;
               end
               sdwc_pkg::OP_FRAME: begin
                  if (running && position < n) begin
                     wg         = wet_share(position, n);
                     want.left  = blend(req_ch.dry_left, req_ch.wet_left, wg);
                     want.right = blend(req_ch.dry_right, req_ch.wet_right, wg);
                     position++;
                     if (position >= n)
                        running = 0;
                  end else begin
                     running    = 0;
                     want.left  = req_ch.wet_left;
                     want.right = req_ch.wet_right;
                  end
                  want.fading      = running;
                  want.frames_left = running ? sdwc_pkg::LEN_W'(n - position) : '0;
                  want.block_end   = req_ch.block_end;
                  mix_queue.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.left        = rsp_ch.mixed_left;
            got.right       = rsp_ch.mixed_right;
            got.fading      = rsp_ch.fading;
            got.frames_left = rsp_ch.frames_left;
            got.block_end   = rsp_ch.block_end_out;
            if (mix_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: L=%0d R=%0d fading=%0b left=%0d end=%0b",
                           got.left, got.right, got.fading, got.frames_left, got.block_end);
            end else begin
               want = mix_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected L=%0d R=%0d fading=%0b left=%0d end=%0b, got L=%0d R=%0d fading=%0b left=%0d end=%0b",
                              want.left, want.right, want.fading, want.frames_left,
                              want.block_end, got.left, got.right, got.fading,
                              got.frames_left, got.block_end);
               end
            end
         end
      end
   end

endmodule

>>> test/stereo_dry_wet_crossfade_tb.sv
// Testbench top for the stereo dry/wet crossfade: drives fades over several
// lengths with random gaps and stalls, and gives the verdict from the checker.
// Depends on sdwc_pkg, sdwc_if.sv, the block and stereo_dry_wet_crossfade_checker.
`timescale 1ns / 1ps

module stereo_dry_wet_crossfade_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_count;
   int   cycles = 0;
   int   hold_cycles = 0;
   int   frames_sent = 0;

   sdwc_req_if req_ch ();
   sdwc_rsp_if rsp_ch ();
   sdwc_csr_if csr_ch ();

   stereo_dry_wet_crossfade i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   stereo_dry_wet_crossfade_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL stereo_dry_wet_crossfade");
         $finish;
      end
   end

   function automatic logic [sdwc_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 24'h7F_FFFF;
         1:       return 24'h80_0000;
         default: return sdwc_pkg::SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: mostly ready, short stalls, occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= (gap_length() == 0) || ($urandom_range(0, 2) == 0);
      end
   end

   task automatic send(input logic [1:0] op, input logic [sdwc_pkg::SAMPLE_W-1:0] wl,
                       input logic [sdwc_pkg::SAMPLE_W-1:0] wr,
                       input logic [sdwc_pkg::SAMPLE_W-1:0] dl,
                       input logic [sdwc_pkg::SAMPLE_W-1:0] dr, input logic be);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     = 1;
      req_ch.operation = op;
      req_ch.wet_left  = wl;
      req_ch.wet_right = wr;
      req_ch.dry_left  = dl;
      req_ch.dry_right = dr;
      req_ch.block_end = be;
      do @(posedge clock); while (!req_ch.ready);
      frames_sent++;
   endtask

   task automatic send_random(input logic [1:0] op);
      send(op, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
           1'($urandom_range(0, 1)));
   endtask

   // Drain every result and let a start or abort still in flight settle.
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 0;
      while (pending_count != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_length(input logic [sdwc_pkg::LEN_W-1:0] len);
      settle();
      @(negedge clock);
      csr_ch.valid = 1;
      csr_ch.data  = len;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 0;
   endtask

   // One fade with random content; sometimes aborted, overrun or restarted.
   task automatic run_fade(input int len);
      int frames;
      frames = $urandom_range(0, len + 3);
      if (frames > 60)
         frames = $urandom_range(20, 60);
      send_random(sdwc_pkg::OP_START);
      for (int k = 0; k < frames; k++) begin
         case ($urandom_range(0, 39))
            0:       send_random(sdwc_pkg::OP_ABORT);
            1:       send_random(sdwc_pkg::OP_START);
            2:       send_random(OP_UNUSED);
            default: send_random(sdwc_pkg::OP_FRAME);
         endcase
      end
   endtask

   initial begin
      int len;
      req_ch.valid     = 0;
      req_ch.operation = sdwc_pkg::OP_FRAME;
      req_ch.wet_left  = '0;
      req_ch.wet_right = '0;
      req_ch.dry_left  = '0;
      req_ch.dry_right = '0;
      req_ch.block_end = 0;
      csr_ch.valid     = 0;
      csr_ch.data      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: idle passthrough, abort while idle, unused code, extremes.
      send(sdwc_pkg::OP_FRAME, 24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'hFF_FFFF, 1);
      send(sdwc_pkg::OP_ABORT, '0, '0, '0, '0, 0);
      send(OP_UNUSED, 24'h12_3456, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 0);
      // Default length: a few frames, restart mid-fade, then abort.
      send(sdwc_pkg::OP_START, '0, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1);
      send(sdwc_pkg::OP_FRAME, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000, 0);
      send(sdwc_pkg::OP_START, '0, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 0);
      send(sdwc_pkg::OP_ABORT, '0, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h00_0001, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 1);
      // Length one, and zero treated as one.
      write_length(13'd1);
      send(sdwc_pkg::OP_START, '0, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 0);
      send(sdwc_pkg::OP_FRAME, 24'h40_0000, 24'hC0_0000, 24'h00_0000, 24'h00_0000, 1);
      write_length(13'd0);
      send(sdwc_pkg::OP_START, '0, '0, '0, '0, 0);
      send(sdwc_pkg::OP_FRAME, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 1);
      // Length two: both ends of the curve, then overrun into passthrough.
      write_length(13'd2);
      send(sdwc_pkg::OP_START, '0, '0, '0, '0, 0);
      for (int k = 0; k < 3; k++)
         send(sdwc_pkg::OP_FRAME, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h7F_FFFF, k[0]);

      // Oversized lengths clamp to the maximum; run part of the fade only.
      write_length(13'h1FFF);
      run_fade(40);
      send_random(sdwc_pkg::OP_ABORT);
      write_length(13'd4097);
      run_fade(40);
      write_length(13'd4096);
      // Hold the receiver off while frames keep coming so the block backs up.
      hold_cycles = 600;
      run_fade(60);

      // Random lengths, mostly short so fades complete.
      while (frames_sent < 1400) begin
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, 3);
            1:       len = $urandom_range(100, 4096);
            default: len = $urandom_range(2, 24);
         endcase
         write_length(sdwc_pkg::LEN_W'(len));
         for (int f = 0; f < 4 && frames_sent < 1400; f++) begin
            if ($urandom_range(0, 9) == 0)
               send_random($urandom_range(0, 1) ? sdwc_pkg::OP_FRAME : OP_UNUSED);
            run_fade(len);
         end
         if ($urandom_range(0, 5) == 0)
            hold_cycles = $urandom_range(100, 300);
      end

      settle();
      if (fail_count == 0 && pending_count == 0)
         $display("PASS stereo_dry_wet_crossfade");
      else
         $display("FAIL stereo_dry_wet_crossfade");
      $finish;
   end

endmodule
